// ===== sv/fbfla_pkg.sv =====
package fbfla_pkg;

    // Pool geometry. A link value of POOL_SIZE stands for the end of the list.
    localparam int POOL_SIZE = 16;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int LINK_W    = $clog2(POOL_SIZE + 1);

    // Result field widths.
    localparam int GRANT_W = 4;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;
    localparam int BIDX_W  = 8;

    // Request codes.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_FOREIGN   = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_POP
    } t_state;

endpackage

// ===== sv/fbfla_link_ram.sv =====
module fbfla_link_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 5
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// ===== sv/fixed_block_free_list_allocator_unit.sv =====
// Channel   Direction  Handshake             Payload
// request   in         start high, busy low  i_action, i_block_index
// result    out        o_valid, one cycle    o_granted_index, o_status, o_free_count
//
// A free, or an allocate on an empty list, is done in the idle state; an allocate that pops
// a block also passes through the pop state, since the link memory read is registered.
// The result strobe is registered and rises in the cycle after the request's last working cycle.
// After reset the chain is built by a pass over all POOL_SIZE (16) entries of the link memory,
// during which busy is high. The receiver cannot stall results.
module fixed_block_free_list_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_action,
    input  logic [fbfla_pkg::BIDX_W-1:0]        i_block_index,
    output logic                                o_valid,
    output logic [fbfla_pkg::GRANT_W-1:0]       o_granted_index,
    output logic [fbfla_pkg::STAT_W-1:0]        o_status,
    output logic [fbfla_pkg::CNT_W-1:0]         o_free_count
);

    localparam logic [fbfla_pkg::LINK_W-1:0] LinkNull = fbfla_pkg::LINK_W'(fbfla_pkg::POOL_SIZE);
    localparam logic [fbfla_pkg::IDX_W-1:0]  LastIdx  =
        fbfla_pkg::IDX_W'(fbfla_pkg::POOL_SIZE - 1);
    localparam logic [fbfla_pkg::CNT_W-1:0]  FullCnt  = fbfla_pkg::CNT_W'(fbfla_pkg::POOL_SIZE);

    fbfla_pkg::t_state                   r_state, n_state;
    logic [fbfla_pkg::IDX_W-1:0]         r_init_cnt, n_init_cnt;
    logic [fbfla_pkg::LINK_W-1:0]        r_head, n_head;
    logic [fbfla_pkg::CNT_W-1:0]         r_count, n_count;
    logic                                r_valid, n_valid;
    logic [fbfla_pkg::GRANT_W-1:0]       r_granted, n_granted;
    fbfla_pkg::t_status                  r_status, n_status;

    logic                                accept;
    logic                                foreign;
    logic                                head_null;
    logic                                ram_wr_en;
    logic [fbfla_pkg::IDX_W-1:0]         ram_wr_addr;
    logic [fbfla_pkg::LINK_W-1:0]        ram_wr_data;
    logic                                ram_rd_en;
    logic [fbfla_pkg::LINK_W-1:0]        ram_rd_data;
    logic [fbfla_pkg::LINK_W-1:0]        next_head;

    // Request decode. Busy is low exactly in the idle state.
    assign accept    = start && (r_state == fbfla_pkg::ST_IDLE);
    assign foreign   = i_block_index >= fbfla_pkg::BIDX_W'(fbfla_pkg::POOL_SIZE);
    assign head_null = r_head >= LinkNull;
    // A link that is not a valid index is taken as the end of the list.
    assign next_head = (ram_rd_data < LinkNull) ? ram_rd_data : LinkNull;

    fbfla_link_ram #(
        .DEPTH (fbfla_pkg::POOL_SIZE),
        .WIDTH (fbfla_pkg::LINK_W)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_head[fbfla_pkg::IDX_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbfla_pkg::ST_INIT: begin
                if (r_init_cnt == LastIdx) begin
                    n_state = fbfla_pkg::ST_IDLE;
                end
            end
            fbfla_pkg::ST_IDLE: begin
                if (accept && i_action == fbfla_pkg::ACT_ALLOC && !head_null) begin
                    n_state = fbfla_pkg::ST_POP;
                end
            end
            fbfla_pkg::ST_POP: begin
                n_state = fbfla_pkg::ST_IDLE;
            end
            default: begin
                n_state = fbfla_pkg::ST_INIT;
            end
        endcase
    end

    // Controller outputs and memory access.
    always_comb begin
        busy        = 1'b1;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_init_cnt;
        ram_wr_data = fbfla_pkg::LINK_W'(r_init_cnt) + fbfla_pkg::LINK_W'(1);
        ram_rd_en   = 1'b0;
        unique case (r_state)
            fbfla_pkg::ST_INIT: begin
                ram_wr_en = 1'b1;
            end
            fbfla_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (accept && i_action == fbfla_pkg::ACT_FREE && !foreign) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = i_block_index[fbfla_pkg::IDX_W-1:0];
                    ram_wr_data = r_head;
                end
                ram_rd_en = accept && i_action == fbfla_pkg::ACT_ALLOC && !head_null;
            end
            fbfla_pkg::ST_POP: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Head, free count and result updates.
    always_comb begin
        n_init_cnt = r_init_cnt;
        n_head     = r_head;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_granted  = '0;
        n_status   = fbfla_pkg::STAT_OK;
        unique case (r_state)
            fbfla_pkg::ST_INIT: begin
                n_init_cnt = r_init_cnt + fbfla_pkg::IDX_W'(1);
            end
            fbfla_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_action == fbfla_pkg::ACT_FREE) begin
                        n_valid = 1'b1;
                        if (foreign) begin
                            n_status = fbfla_pkg::STAT_FOREIGN;
                        end else begin
                            n_head = fbfla_pkg::LINK_W'(i_block_index[fbfla_pkg::IDX_W-1:0]);
                            if (r_count < FullCnt) begin
                                n_count = r_count + fbfla_pkg::CNT_W'(1);
                            end
                        end
                    end else if (head_null) begin
                        n_valid  = 1'b1;
                        n_status = fbfla_pkg::STAT_EXHAUSTED;
                    end
                end
            end
            fbfla_pkg::ST_POP: begin
                n_valid   = 1'b1;
                n_granted = r_head[fbfla_pkg::GRANT_W-1:0];
                n_head    = next_head;
                if (r_count != '0) begin
                    n_count = r_count - fbfla_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fbfla_pkg::ST_INIT;
            r_init_cnt <= '0;
            r_head     <= '0;
            r_count    <= FullCnt;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init_cnt <= n_init_cnt;
            r_head     <= n_head;
            r_count    <= n_count;
            r_valid    <= n_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_valid         = r_valid;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;
    assign o_free_count    = r_count;

`ifndef SYNTH
    // A free request, taken or refused, reports in the following cycle.
    a_free_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_action == fbfla_pkg::ACT_FREE |=> o_valid)
        else $error("free transaction gave no result");

    // A pop always completes from the memory read and never stalls further.
    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fbfla_pkg::ST_POP |=> o_valid && o_status == fbfla_pkg::STAT_OK)
        else $error("pop did not complete with a grant");

    // The free count never exceeds the pool.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("free count out of range");

    // A grant index is only reported with an ok status.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != fbfla_pkg::STAT_OK |-> o_granted_index == '0)
        else $error("failed transaction carried a grant index");
`endif

endmodule
